>>> rtl/fbfe_pkg.sv
// Package for the frame buffer fill engine: sizes, command and op codes,
// the command descriptor passed from front end to back end, and box clipping.
// No dependencies.
package fbfe_pkg;

   localparam int DefFrameW  = 320;
   localparam int DefFrameH  = 240;
   localparam int ModeW      = 3;
   localparam int PosW       = 10;
   localparam int ExtW       = 11;
   localparam int ThickW     = 8;
   localparam int ColorW     = 8;
   localparam int CoordW     = 11;
   localparam int SCoordW    = 13;
   localparam int NumBoxes   = 4;
   localparam int BoxIdxW    = $clog2(NumBoxes);
   localparam int QueueDepth = 2;
   localparam int QPtrW      = $clog2(QueueDepth);
   localparam int QCntW      = $clog2(QueueDepth + 1);

   typedef enum logic [ModeW-1:0] {
      MODE_FILL_ALL   = 3'd0,
      MODE_SET_PIXEL  = 3'd1,
      MODE_FILL_RECT  = 3'd2,
      MODE_OUTLINE    = 3'd3,
      MODE_HLINE      = 3'd4,
      MODE_VLINE      = 3'd5,
      MODE_READ_PIXEL = 3'd6
   } mode_type;

   typedef enum logic [1:0] {
      OP_NONE  = 2'd0,
      OP_WRITE = 2'd1,
      OP_READ  = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      FRONT_IDLE = 2'd0,
      FRONT_CALC = 2'd1,
      FRONT_PUSH = 2'd2
   } front_state_type;

   typedef enum logic [2:0] {
      BACK_IDLE  = 3'd0,
      BACK_SETUP = 3'd1,
      BACK_RUN   = 3'd2,
      BACK_READ  = 3'd3,
      BACK_WAIT  = 3'd4,
      BACK_RESP  = 3'd5
   } back_state_type;

   typedef struct packed {
      logic [ModeW-1:0]  mode;
      logic [PosW-1:0]   x_pos;
      logic [PosW-1:0]   y_pos;
      logic [ExtW-1:0]   extent_x;
      logic [ExtW-1:0]   extent_y;
      logic [ThickW-1:0] thickness;
      logic [ColorW-1:0] color;
   } cmd_type;

   // Half-open box of columns [xa,xb) and rows [ya,yb), already clipped.
   typedef struct packed {
      logic [CoordW-1:0] xa;
      logic [CoordW-1:0] xb;
      logic [CoordW-1:0] ya;
      logic [CoordW-1:0] yb;
   } box_type;

   typedef struct packed {
      op_type                       op;
      logic                         accepted;
      logic [ColorW-1:0]            color;
      box_type [NumBoxes-1:0]       boxes;
   } desc_type;

   function automatic logic [CoordW-1:0] clip_coord(logic signed [SCoordW-1:0] v,
                                                    logic [CoordW-1:0] lim);
      logic signed [SCoordW-1:0] lim_s;
      logic [CoordW-1:0]         res;
      lim_s = $signed(SCoordW'(lim));
      if (v < 0) begin
         res = '0;
      end else if (v > lim_s) begin
         res = lim;
      end else begin
         res = v[CoordW-1:0];
      end
      return res;
   endfunction

   function automatic box_type make_box(logic signed [SCoordW-1:0] xa,
                                        logic signed [SCoordW-1:0] xb,
                                        logic signed [SCoordW-1:0] ya,
                                        logic signed [SCoordW-1:0] yb,
                                        logic [CoordW-1:0] wlim,
                                        logic [CoordW-1:0] hlim);
      box_type b;
      b.xa = clip_coord(xa, wlim);
      b.xb = clip_coord(xb, wlim);
      b.ya = clip_coord(ya, hlim);
      b.yb = clip_coord(yb, hlim);
      return b;
   endfunction

endpackage

>>> rtl/fbfe_if.sv
// Channel interfaces of the frame buffer fill engine: command and response.
// Depends on fbfe_pkg.
interface fbfe_req_if import fbfe_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ModeW-1:0]  mode;
   logic [PosW-1:0]   x_pos;
   logic [PosW-1:0]   y_pos;
   logic [ExtW-1:0]   extent_x;
   logic [ExtW-1:0]   extent_y;
   logic [ThickW-1:0] thickness;
   logic [ColorW-1:0] color;

   modport source (output valid, mode, x_pos, y_pos, extent_x, extent_y, thickness, color,
                   input ready);
   modport sink (input valid, mode, x_pos, y_pos, extent_x, extent_y, thickness, color,
                 output ready);
endinterface

interface fbfe_rsp_if import fbfe_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ColorW-1:0] pixel_value;
   logic              accepted;

   modport source (output valid, pixel_value, accepted, input ready);
   modport sink (input valid, pixel_value, accepted, output ready);
endinterface

>>> rtl/fbfe_ram.sv
// Generic single-port RAM with a registered read.
// No dependencies.
module fbfe_ram #(
   parameter int  DATA_W = 8,
   parameter int  DEPTH  = 1024,
   localparam int AddrW  = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic              rd_en,
   input  logic [AddrW-1:0]  addr,
   input  logic [DATA_W-1:0] wr_data,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/fbfe_front.sv
// Front end: accepts a command beat, checks bounds and turns it into up to four
// clipped boxes for the back end. Depends on fbfe_pkg and fbfe_if.
module fbfe_front import fbfe_pkg::*; #(
   parameter int FRAME_W = DefFrameW,
   parameter int FRAME_H = DefFrameH
) (
   input  logic        clock,
   input  logic        reset,
   fbfe_req_if.sink    req_chan,
   output desc_type    push_data,
   output logic        push_valid,
   input  logic        push_ready
);

   localparam logic [CoordW-1:0]         FrameWC = CoordW'(FRAME_W);
   localparam logic [CoordW-1:0]         FrameHC = CoordW'(FRAME_H);
   localparam logic signed [SCoordW-1:0] FrameWS = SCoordW'(FRAME_W);
   localparam logic signed [SCoordW-1:0] FrameHS = SCoordW'(FRAME_H);
   localparam logic signed [SCoordW-1:0] OneS    = SCoordW'(1);
   localparam logic signed [SCoordW-1:0] ZeroS   = '0;

   front_state_type           state_ff, state_in;
   cmd_type                   cmd_ff, cmd_in;
   logic signed [SCoordW-1:0] x2_ff, x2_in, y2_ff, y2_in;

   logic signed [SCoordW-1:0] xp_s, yp_s, ex_s, ey_s, t_s;
   logic signed [SCoordW-1:0] sum_x, sum_y;
   logic                      org_ok;
   desc_type                  desc;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      x2_ff  <= x2_in;
      y2_ff  <= y2_in;
   end

   assign xp_s  = $signed(SCoordW'(cmd_ff.x_pos));
   assign yp_s  = $signed(SCoordW'(cmd_ff.y_pos));
   assign ex_s  = $signed(SCoordW'(cmd_ff.extent_x));
   assign ey_s  = $signed(SCoordW'(cmd_ff.extent_y));
   assign t_s   = $signed(SCoordW'(cmd_ff.thickness));
   assign sum_x = xp_s + ex_s;
   assign sum_y = yp_s + ey_s;
   assign org_ok = (CoordW'(cmd_ff.x_pos) < FrameWC) && (CoordW'(cmd_ff.y_pos) < FrameHC);

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      x2_in          = x2_ff;
      y2_in          = y2_ff;
      req_chan.ready = 1'b0;
      push_valid     = 1'b0;
      case (state_ff)
         FRONT_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               cmd_in.mode      = req_chan.mode;
               cmd_in.x_pos     = req_chan.x_pos;
               cmd_in.y_pos     = req_chan.y_pos;
               cmd_in.extent_x  = req_chan.extent_x;
               cmd_in.extent_y  = req_chan.extent_y;
               cmd_in.thickness = req_chan.thickness;
               cmd_in.color     = req_chan.color;
               state_in         = FRONT_CALC;
            end
         end
         FRONT_CALC: begin
            // Outline far corners; when they reach the frame edge they are pulled
            // back by the thickness and may go negative.
            x2_in    = (sum_x >= FrameWS) ? FrameWS - t_s : sum_x;
            y2_in    = (sum_y >= FrameHS) ? FrameHS - t_s : sum_y;
            state_in = FRONT_PUSH;
         end
         FRONT_PUSH: begin
            push_valid = 1'b1;
            if (push_ready) begin
               state_in = FRONT_IDLE;
            end
         end
         default: begin
            state_in = FRONT_IDLE;
         end
      endcase
   end

   always_comb begin
      desc.op       = OP_NONE;
      desc.accepted = 1'b0;
      desc.color    = cmd_ff.color;
      desc.boxes    = '0;
      case (cmd_ff.mode)
         MODE_FILL_ALL: begin
            desc.op       = OP_WRITE;
            desc.accepted = 1'b1;
            desc.boxes[0] = make_box(ZeroS, FrameWS, ZeroS, FrameHS, FrameWC, FrameHC);
         end
         MODE_SET_PIXEL: begin
            if (org_ok) begin
               desc.op       = OP_WRITE;
               desc.accepted = 1'b1;
               desc.boxes[0] = make_box(xp_s, xp_s + OneS, yp_s, yp_s + OneS,
                                        FrameWC, FrameHC);
            end
         end
         MODE_FILL_RECT: begin
            if (org_ok) begin
               desc.op       = OP_WRITE;
               desc.accepted = 1'b1;
               desc.boxes[0] = make_box(xp_s, sum_x, yp_s, sum_y, FrameWC, FrameHC);
            end
         end
         MODE_OUTLINE: begin
            if (org_ok) begin
               desc.op       = OP_WRITE;
               desc.accepted = 1'b1;
               desc.boxes[0] = make_box(xp_s, x2_ff + t_s, yp_s, yp_s + t_s,
                                        FrameWC, FrameHC);
               desc.boxes[1] = make_box(xp_s, xp_s + t_s, yp_s + t_s, y2_ff,
                                        FrameWC, FrameHC);
               desc.boxes[2] = make_box(x2_ff, x2_ff + t_s, yp_s + t_s, y2_ff,
                                        FrameWC, FrameHC);
               desc.boxes[3] = make_box(xp_s, x2_ff + t_s, y2_ff, y2_ff + t_s,
                                        FrameWC, FrameHC);
            end
         end
         MODE_HLINE: begin
            if (org_ok && (cmd_ff.extent_x < FrameWC)) begin
               desc.op       = OP_WRITE;
               desc.accepted = 1'b1;
               if (xp_s < ex_s) begin
                  desc.boxes[0] = make_box(xp_s, ex_s, yp_s, yp_s + OneS, FrameWC, FrameHC);
               end else begin
                  desc.boxes[0] = make_box(ex_s + OneS, xp_s + OneS, yp_s, yp_s + OneS,
                                           FrameWC, FrameHC);
               end
            end
         end
         MODE_VLINE: begin
            if (org_ok && (cmd_ff.extent_y < FrameHC)) begin
               desc.op       = OP_WRITE;
               desc.accepted = 1'b1;
               if (yp_s < ey_s) begin
                  desc.boxes[0] = make_box(xp_s, xp_s + OneS, yp_s, ey_s, FrameWC, FrameHC);
               end else begin
                  desc.boxes[0] = make_box(xp_s, xp_s + OneS, ey_s + OneS, yp_s + OneS,
                                           FrameWC, FrameHC);
               end
            end
         end
         MODE_READ_PIXEL: begin
            if (org_ok) begin
               desc.op       = OP_READ;
               desc.accepted = 1'b1;
               desc.boxes[0] = make_box(xp_s, xp_s + OneS, yp_s, yp_s + OneS,
                                        FrameWC, FrameHC);
            end
         end
         default: begin
            desc.op = OP_NONE;
         end
      endcase
   end

   assign push_data = desc;

endmodule

>>> rtl/fbfe_fifo.sv
// Short descriptor queue between the front end and the back end.
// Depends on fbfe_pkg.
module fbfe_fifo import fbfe_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  desc_type push_data,
   input  logic     push_valid,
   output logic     push_ready,
   output desc_type pop_data,
   output logic     pop_valid,
   input  logic     pop_ready
);

   desc_type         entry_ff [QueueDepth];
   logic [QPtrW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCntW-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != QCntW'(QueueDepth));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/fbfe_back.sv
// Back end: walks the boxes of a descriptor one pixel per cycle into the frame
// store, or reads one pixel, then loads the response register. Depends on fbfe_pkg, fbfe_if.
module fbfe_back import fbfe_pkg::*; #(
   parameter int  FRAME_W = DefFrameW,
   parameter int  FRAME_H = DefFrameH,
   localparam int AddrW   = $clog2(FRAME_W * FRAME_H)
) (
   input  logic              clock,
   input  logic              reset,
   input  desc_type          pop_data,
   input  logic              pop_valid,
   output logic              pop_ready,
   fbfe_rsp_if.source        rsp_chan,
   output logic              ram_wr_en,
   output logic              ram_rd_en,
   output logic [AddrW-1:0]  ram_addr,
   output logic [ColorW-1:0] ram_wr_data,
   input  logic [ColorW-1:0] ram_rd_data
);

   localparam logic [AddrW-1:0] RowStep = AddrW'(FRAME_W);

   back_state_type     state_ff, state_in;
   desc_type           desc_ff, desc_in;
   logic [BoxIdxW-1:0] box_idx_ff, box_idx_in;
   logic [CoordW-1:0]  x_ff, x_in, y_ff, y_in;
   logic [AddrW-1:0]   row_base_ff, row_base_in;
   logic [ColorW-1:0]  pix_ff, pix_in;
   logic               out_valid_ff, out_valid_in;
   logic [ColorW-1:0]  out_pix_ff, out_pix_in;
   logic               out_acc_ff, out_acc_in;
   box_type            cur_box;
   logic               last_box;

   assign cur_box     = desc_ff.boxes[box_idx_ff];
   assign last_box    = (box_idx_ff == BoxIdxW'(NumBoxes - 1));
   assign ram_addr    = row_base_ff + AddrW'(x_ff);
   assign ram_wr_data = desc_ff.color;

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.pixel_value = out_pix_ff;
   assign rsp_chan.accepted    = out_acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      desc_ff     <= desc_in;
      box_idx_ff  <= box_idx_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      row_base_ff <= row_base_in;
      pix_ff      <= pix_in;
      out_pix_ff  <= out_pix_in;
      out_acc_ff  <= out_acc_in;
   end

   always_comb begin
      state_in     = state_ff;
      desc_in      = desc_ff;
      box_idx_in   = box_idx_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      row_base_in  = row_base_ff;
      pix_in       = pix_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_pix_in   = out_pix_ff;
      out_acc_in   = out_acc_ff;
      pop_ready    = 1'b0;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      case (state_ff)
         BACK_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               desc_in    = pop_data;
               box_idx_in = '0;
               pix_in     = '0;
               state_in   = BACK_SETUP;
            end
         end
         BACK_SETUP: begin
            x_in        = cur_box.xa;
            y_in        = cur_box.ya;
            row_base_in = AddrW'(AddrW'(cur_box.ya) * RowStep);
            case (desc_ff.op)
               OP_READ: begin
                  state_in = BACK_READ;
               end
               OP_WRITE: begin
                  if ((cur_box.xa < cur_box.xb) && (cur_box.ya < cur_box.yb)) begin
                     state_in = BACK_RUN;
                  end else if (last_box) begin
                     state_in = BACK_RESP;
                  end else begin
                     box_idx_in = box_idx_ff + 1'b1;
                  end
               end
               default: begin
                  state_in = BACK_RESP;
               end
            endcase
         end
         BACK_RUN: begin
            ram_wr_en = 1'b1;
            if ((x_ff + 1'b1) == cur_box.xb) begin
               x_in        = cur_box.xa;
               y_in        = y_ff + 1'b1;
               row_base_in = row_base_ff + RowStep;
               if ((y_ff + 1'b1) == cur_box.yb) begin
                  if (last_box) begin
                     state_in = BACK_RESP;
                  end else begin
                     box_idx_in = box_idx_ff + 1'b1;
                     state_in   = BACK_SETUP;
                  end
               end
            end else begin
               x_in = x_ff + 1'b1;
            end
         end
         BACK_READ: begin
            ram_rd_en = 1'b1;
            state_in  = BACK_WAIT;
         end
         BACK_WAIT: begin
            pix_in   = ram_rd_data;
            state_in = BACK_RESP;
         end
         BACK_RESP: begin
            if (!out_valid_ff || rsp_chan.ready) begin
               out_valid_in = 1'b1;
               out_pix_in   = pix_ff;
               out_acc_in   = desc_ff.accepted;
               state_in     = BACK_IDLE;
            end
         end
         default: begin
            state_in = BACK_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/framebuffer_fill_engine.sv
// Frame buffer fill engine top level: front end, descriptor queue, back end
// and frame store. Depends on fbfe_pkg, fbfe_if, fbfe_ram, fbfe_front, fbfe_fifo, fbfe_back.
//
// Usage: drawing commands arrive as beats on req_chan (valid/ready); each command
// produces exactly one response beat on rsp_chan carrying pixel_value and accepted.
// The front end takes a command, classifies it and clips it into up to four boxes,
// and places it in a two-entry queue. For a write command the back end visits all
// four boxes, with a setup state for each, and writes one pixel per cycle through
// the single port of the frame store. A pixel read goes through the registered read
// of the frame store. The back end takes the next descriptor only after loading the
// response register, and the front end takes a new command only after it has pushed
// the last one into the queue. A response also waits behind earlier commands in the
// queue.
// The response sits in an output register; while the receiver stalls, the back end
// finishes its command and waits, and the front end keeps accepting commands until
// the queue is full. Reset clears the control state and empties the queue; the frame
// store is not cleared and holds undefined data until written.
module framebuffer_fill_engine import fbfe_pkg::*; #(
   parameter int FRAME_W = DefFrameW,
   parameter int FRAME_H = DefFrameH
) (
   input  logic       clock,
   input  logic       reset,
   fbfe_req_if.sink   req_chan,
   fbfe_rsp_if.source rsp_chan
);

   localparam int Depth = FRAME_W * FRAME_H;
   localparam int AddrW = $clog2(Depth);

   desc_type          push_data, pop_data;
   logic              push_valid, push_ready, pop_valid, pop_ready;
   logic              ram_wr_en, ram_rd_en;
   logic [AddrW-1:0]  ram_addr;
   logic [ColorW-1:0] ram_wr_data, ram_rd_data;

   fbfe_front #(
      .FRAME_W (FRAME_W),
      .FRAME_H (FRAME_H)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push_data  (push_data),
      .push_valid (push_valid),
      .push_ready (push_ready)
   );

   fbfe_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_data  (push_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .pop_data   (pop_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready)
   );

   fbfe_back #(
      .FRAME_W (FRAME_W),
      .FRAME_H (FRAME_H)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_data    (pop_data),
      .pop_valid   (pop_valid),
      .pop_ready   (pop_ready),
      .rsp_chan    (rsp_chan),
      .ram_wr_en   (ram_wr_en),
      .ram_rd_en   (ram_rd_en),
      .ram_addr    (ram_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_data (ram_rd_data)
   );

   fbfe_ram #(
      .DATA_W (ColorW),
      .DEPTH  (Depth)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .rd_en   (ram_rd_en),
      .addr    (ram_addr),
      .wr_data (ram_wr_data),
      .rd_data (ram_rd_data)
   );

endmodule

>>> tb/sv/framebuffer_fill_engine_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for framebuffer_fill_engine: directed and random drawing commands
// checked against a pixel-accurate frame store kept in the testbench.
// Depends on fbfe_pkg, fbfe_if and the framebuffer_fill_engine RTL.
module framebuffer_fill_engine_tb;
   import fbfe_pkg::*;

   localparam int ClockPeriod = 4;
   localparam int FrameW = DefFrameW;
   localparam int FrameH = DefFrameH;
   localparam int FrameAddrW = $clog2(FrameW * FrameH);
   localparam int RandomItems = 75;
   localparam int PixelBudget = 1500;
   localparam int CalmItems = 15;
   localparam int HoldOffset = 30;
   localparam int LongHold = 3000;
   localparam int DrainCycles = 50;
   localparam int CycleLimit = 2000000;
   localparam logic [ModeW-1:0] ModeUnused = 3'd7;

   typedef struct packed {
      logic [CoordW-1:0] xa;
      logic [CoordW-1:0] xb;
      logic [CoordW-1:0] ya;
      logic [CoordW-1:0] yb;
   } span_box;

   typedef struct packed {
      logic                   ok;
      logic [2:0]             count;
      span_box [NumBoxes-1:0] boxes;
   } draw_plan;

   typedef struct packed {
      logic [ColorW-1:0] pixel_value;
      logic              accepted;
   } pixel_reply;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fbfe_req_if req_chan ();
   fbfe_rsp_if rsp_chan ();

   framebuffer_fill_engine #(
      .FRAME_W(FrameW),
      .FRAME_H(FrameH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   logic [ColorW-1:0] frame_mem [FrameW*FrameH];
   cmd_type cmd_backlog[$];
   cmd_type on_bus;
   pixel_reply replies_due[$];
   pixel_reply want;
   int items_issued = 0;
   int total_items = 0;
   int cmds_taken = 0;
   int results_seen = 0;
   int mismatches = 0;
   int cycle_count = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   int req_gap = 0;
   int rsp_gap = 0;
   int fill_all_left = 1;

   wire calm = (cmds_taken + CalmItems >= total_items);

   always #(ClockPeriod / 2) clock = ~clock;

   function automatic int clamp_to(int v, int hi);
      return (v < 0) ? 0 : ((v > hi) ? hi : v);
   endfunction

   function automatic span_box clip_box(int xa, int xb, int ya, int yb);
      span_box s;
      s.xa = CoordW'(clamp_to(xa, FrameW));
      s.xb = CoordW'(clamp_to(xb, FrameW));
      s.ya = CoordW'(clamp_to(ya, FrameH));
      s.yb = CoordW'(clamp_to(yb, FrameH));
      return s;
   endfunction

   // Turns a command into its acceptance and the clipped boxes of pixels it writes.
   function automatic draw_plan plan_command(cmd_type c);
      draw_plan p;
      int xp, yp, ex, ey, t, x2, y2;
      bit org;
      xp = int'(c.x_pos);
      yp = int'(c.y_pos);
      ex = int'(c.extent_x);
      ey = int'(c.extent_y);
      t = int'(c.thickness);
      org = (xp < FrameW) && (yp < FrameH);
      p = '0;
      case (c.mode)
         MODE_FILL_ALL: begin
            p.ok = 1'b1;
            p.count = 3'd1;
            p.boxes[0] = clip_box(0, FrameW, 0, FrameH);
         end
         MODE_SET_PIXEL: begin
            if (org) begin
               p.ok = 1'b1;
               p.count = 3'd1;
               p.boxes[0] = clip_box(xp, xp + 1, yp, yp + 1);
            end
         end
         MODE_FILL_RECT: begin
            if (org) begin
               p.ok = 1'b1;
               p.count = 3'd1;
               p.boxes[0] = clip_box(xp, xp + ex, yp, yp + ey);
            end
         end
         MODE_OUTLINE: begin
            if (org) begin
               x2 = xp + ex;
               y2 = yp + ey;
               if (x2 >= FrameW) x2 = FrameW - t;
               if (y2 >= FrameH) y2 = FrameH - t;
               p.ok = 1'b1;
               p.count = 3'd4;
               p.boxes[0] = clip_box(xp, x2 + t, yp, yp + t);
               p.boxes[1] = clip_box(xp, xp + t, yp + t, y2);
               p.boxes[2] = clip_box(x2, x2 + t, yp + t, y2);
               p.boxes[3] = clip_box(xp, x2 + t, y2, y2 + t);
            end
         end
         MODE_HLINE: begin
            if (yp < FrameH && xp < FrameW && ex < FrameW) begin
               p.ok = 1'b1;
               p.count = 3'd1;
               p.boxes[0] = (xp < ex) ? clip_box(xp, ex, yp, yp + 1)
                                      : clip_box(ex + 1, xp + 1, yp, yp + 1);
            end
         end
         MODE_VLINE: begin
            if (xp < FrameW && yp < FrameH && ey < FrameH) begin
               p.ok = 1'b1;
               p.count = 3'd1;
               p.boxes[0] = (yp < ey) ? clip_box(xp, xp + 1, yp, ey)
                                      : clip_box(xp, xp + 1, ey + 1, yp + 1);
            end
         end
         MODE_READ_PIXEL: begin
            p.ok = org;
         end
         default: ;
      endcase
      return p;
   endfunction

   // Applies one command to the frame store and returns the reply it must produce.
   function automatic pixel_reply run_command(cmd_type c);
      draw_plan p;
      pixel_reply r;
      int b, x, y;
      p = plan_command(c);
      r.pixel_value = '0;
      r.accepted = p.ok;
      if (p.ok && c.mode == MODE_READ_PIXEL) begin
         r.pixel_value = frame_mem[FrameAddrW'(int'(c.y_pos) * FrameW + int'(c.x_pos))];
      end
      for (b = 0; b < int'(p.count); b++) begin
         for (y = int'(p.boxes[b].ya); y < int'(p.boxes[b].yb); y++) begin
            for (x = int'(p.boxes[b].xa); x < int'(p.boxes[b].xb); x++) begin
               frame_mem[FrameAddrW'(y * FrameW + x)] = c.color;
            end
         end
      end
      return r;
   endfunction

   // Random command whose pixel work stays small; at most one full-frame fill is let through.
   function automatic cmd_type random_command();
      cmd_type c;
      draw_plan p;
      int cost, b, pick, w, h;
      do begin
         pick = $urandom_range(0, 99);
         c.mode = (pick < 2)  ? MODE_FILL_ALL  :
                  (pick < 17) ? MODE_SET_PIXEL :
                  (pick < 32) ? MODE_FILL_RECT :
                  (pick < 47) ? MODE_OUTLINE   :
                  (pick < 59) ? MODE_HLINE     :
                  (pick < 71) ? MODE_VLINE     :
                  (pick < 96) ? MODE_READ_PIXEL : ModeUnused;
         if (c.mode == MODE_FILL_ALL) begin
            if (fill_all_left > 0) fill_all_left--;
            else c.mode = MODE_READ_PIXEL;
         end
         c.x_pos = ($urandom_range(0, 99) < 85) ? PosW'($urandom_range(0, FrameW - 1))
                                                : PosW'($urandom_range(0, 1023));
         c.y_pos = ($urandom_range(0, 99) < 85) ? PosW'($urandom_range(0, FrameH - 1))
                                                : PosW'($urandom_range(0, 1023));
         pick = $urandom_range(0, 99);
         c.extent_x = (pick < 50) ? ExtW'($urandom_range(0, 40)) :
                      (pick < 80) ? ExtW'($urandom_range(0, FrameW - 1)) :
                                    ExtW'($urandom_range(0, 2047));
         pick = $urandom_range(0, 99);
         c.extent_y = (pick < 50) ? ExtW'($urandom_range(0, 40)) :
                      (pick < 80) ? ExtW'($urandom_range(0, FrameH - 1)) :
                                    ExtW'($urandom_range(0, 2047));
         c.thickness = ($urandom_range(0, 99) < 60) ? ThickW'($urandom_range(0, 6))
                                                    : ThickW'($urandom_range(0, 255));
         c.color = ColorW'($urandom_range(0, 255));
         p = plan_command(c);
         cost = 0;
         for (b = 0; b < int'(p.count); b++) begin
            w = int'(p.boxes[b].xb) - int'(p.boxes[b].xa);
            h = int'(p.boxes[b].yb) - int'(p.boxes[b].ya);
            if (w > 0 && h > 0) cost += w * h;
         end
      end while (cost > PixelBudget && c.mode != MODE_FILL_ALL);
      return c;
   endfunction

   task automatic post_command(logic [ModeW-1:0] mode, int x, int y, int ex, int ey,
                               int t, int color);
      cmd_type c;
      c.mode = mode;
      c.x_pos = PosW'(x);
      c.y_pos = PosW'(y);
      c.extent_x = ExtW'(ex);
      c.extent_y = ExtW'(ey);
      c.thickness = ThickW'(t);
      c.color = ColorW'(color);
      cmd_backlog.push_back(c);
      items_issued++;
   endtask

   task automatic report_mismatch(string what);
      $display("ERROR at response beat %0d: %s", results_seen, what);
      mismatches++;
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("framebuffer_fill_engine test failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_gap = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            replies_due.push_back(run_command(on_bus));
            cmds_taken <= cmds_taken + 1;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (req_gap > 0) begin
               req_gap--;
               req_chan.valid <= 1'b0;
            end else if (cmd_backlog.size() > 0 && !calm && $urandom_range(0, 5) == 0) begin
               req_gap = $urandom_range(0, 4);
               req_chan.valid <= 1'b0;
            end else if (cmd_backlog.size() > 0) begin
               on_bus = cmd_backlog.pop_front();
               req_chan.valid <= 1'b1;
               req_chan.mode <= on_bus.mode;
               req_chan.x_pos <= on_bus.x_pos;
               req_chan.y_pos <= on_bus.y_pos;
               req_chan.extent_x <= on_bus.extent_x;
               req_chan.extent_y <= on_bus.extent_y;
               req_chan.thickness <= on_bus.thickness;
               req_chan.color <= on_bus.color;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && cmds_taken >= total_items - RandomItems + HoldOffset) begin
         hold_left <= LongHold;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_gap = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (replies_due.size() == 0) begin
               report_mismatch("response beat with no command outstanding");
            end else begin
               want = replies_due.pop_front();
               if (rsp_chan.pixel_value !== want.pixel_value) begin
                  report_mismatch($sformatf("pixel_value %h, expected %h",
                                            rsp_chan.pixel_value, want.pixel_value));
               end
               if (rsp_chan.accepted !== want.accepted) begin
                  report_mismatch($sformatf("accepted %b, expected %b",
                                            rsp_chan.accepted, want.accepted));
               end
            end
            results_seen <= results_seen + 1;
         end
         if (hold_left != 0) begin
            rsp_chan.ready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_chan.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            rsp_gap = $urandom_range(0, 4);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   initial begin
      int n;

      // The first command writes every pixel, so no later read sees unwritten memory.
      post_command(MODE_FILL_ALL, 0, 0, 0, 0, 0, 8'hA5);
      post_command(MODE_READ_PIXEL, 0, 0, 0, 0, 0, 0);
      post_command(MODE_FILL_RECT, 0, 0, 2047, 2047, 0, 8'h3C);
      post_command(MODE_READ_PIXEL, 319, 239, 0, 0, 0, 0);
      post_command(MODE_READ_PIXEL, 320, 0, 0, 0, 0, 0);
      post_command(MODE_READ_PIXEL, 1023, 1023, 0, 0, 0, 0);
      post_command(MODE_SET_PIXEL, 319, 239, 0, 0, 0, 8'hFF);
      post_command(MODE_SET_PIXEL, 0, 0, 0, 0, 0, 8'h00);
      post_command(MODE_SET_PIXEL, 320, 239, 0, 0, 0, 8'h11);
      post_command(MODE_READ_PIXEL, 319, 239, 0, 0, 0, 0);
      post_command(MODE_FILL_RECT, 300, 230, 2047, 2047, 0, 8'h5A);
      post_command(MODE_FILL_RECT, 10, 10, 0, 0, 0, 8'h77);
      post_command(MODE_FILL_RECT, 1023, 0, 5, 5, 0, 8'h78);
      post_command(MODE_OUTLINE, 100, 100, 20, 10, 2, 8'h33);
      post_command(MODE_OUTLINE, 310, 235, 2047, 2047, 255, 8'hC3);
      post_command(MODE_OUTLINE, 50, 50, 10, 10, 0, 8'h99);
      post_command(MODE_READ_PIXEL, 121, 109, 0, 0, 0, 0);
      post_command(MODE_HLINE, 5, 50, 40, 0, 0, 8'h44);
      post_command(MODE_HLINE, 300, 60, 2, 0, 0, 8'h45);
      post_command(MODE_HLINE, 30, 61, 30, 0, 0, 8'h46);
      post_command(MODE_HLINE, 0, 62, 320, 0, 0, 8'h47);
      post_command(MODE_HLINE, 0, 239, 2047, 0, 0, 8'h48);
      post_command(MODE_VLINE, 7, 3, 0, 200, 0, 8'h49);
      post_command(MODE_VLINE, 8, 239, 0, 0, 0, 8'h4A);
      post_command(MODE_VLINE, 9, 0, 0, 240, 0, 8'h4B);
      post_command(ModeUnused, 1023, 1023, 2047, 2047, 255, 8'hFF);
      post_command(MODE_READ_PIXEL, 300, 60, 0, 0, 0, 0);
      total_items = items_issued + RandomItems;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (results_seen != items_issued) @(posedge clock);
      @(negedge clock);
      for (n = 0; n < RandomItems; n++) begin
         cmd_backlog.push_back(random_command());
         items_issued++;
      end

      while (results_seen != items_issued) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (replies_due.size() != 0) begin
         report_mismatch($sformatf("%0d responses never arrived", replies_due.size()));
      end
      if (mismatches == 0) begin
         $display("framebuffer_fill_engine test passed");
      end else begin
         $display("framebuffer_fill_engine test failed");
      end
      $finish;
   end

endmodule

>>> framebuffer_fill_engine.f
rtl/fbfe_pkg.sv
rtl/fbfe_if.sv
rtl/fbfe_ram.sv
rtl/fbfe_front.sv
rtl/fbfe_fifo.sv
rtl/fbfe_back.sv
rtl/framebuffer_fill_engine.sv
tb/sv/framebuffer_fill_engine_tb.sv
